// ===== sv/rhmpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Rolling hash filter package
// Shared payload types, action codes, register indexes and hash constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhmpf_pkg;

    localparam int CHAR_W = 8;
    localparam int SLOT_W = 6;
    localparam int HASH_W = 30;
    localparam int POS_W  = 32;
    localparam int WLEN_W = 6;

    // hash modulus; 2^30 folds to 35 modulo this value
    localparam logic [HASH_W-1:0] HASH_Q    = 30'd1073741789;
    localparam logic [HASH_W:0]   HASH_FOLD = (31'd1 << HASH_W) - {1'b0, HASH_Q};

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADING_WEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [CHAR_W-1:0]   char_code;
        logic [SLOT_W-1:0]   slot_index;
        logic [HASH_W-1:0]   pattern_hash;
    } t_in;

    typedef struct packed {
        logic                hash_valid;
        logic [HASH_W-1:0]   window_hash;
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
        logic [POS_W-1:0]    window_start;
    } t_out;

    typedef struct packed {
        logic [WLEN_W-1:0]   word_length;
        logic [HASH_W-1:0]   leading_weight;
    } t_cfg;

    // request travelling down the slot chain
    typedef struct packed {
        logic                vld;
        t_action             action;
        logic [SLOT_W-1:0]   slot_index;
        logic [HASH_W-1:0]   pattern_hash;
        logic                hash_valid;
        logic [HASH_W-1:0]   window_hash;
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
        logic [POS_W-1:0]    window_start;
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_MUL    = 2'd1,
        S_FOLD   = 2'd2,
        S_REDUCE = 2'd3
    } t_state;

endpackage

`default_nettype wire

// ===== sv/rhmpf_hash_unit.sv =====
// ----------------------------------------------------------------------------
// Rolling hash front end
// Character window shift line, modular roll of the hash over three steps,
// position count, and issue of one request per item into the slot chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhmpf_hash_unit
    import rhmpf_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    input  wire t_cfg i_cfg,
    input  wire logic i_adv,
    output t_req      o_req
);

    localparam int IDX_W = $clog2(WINDOW_MAX);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [POS_W-1:0]  r_cs, n_cs;

    logic [CHAR_W-1:0] r_win [WINDOW_MAX];
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] r_leave;
    logic              r_full;
    logic              r_hv;
    logic [POS_W-1:0]  r_ws;
    logic [37:0]       r_prod;
    logic [HASH_W:0]   r_fold;

    logic              w_accept;
    logic              w_take_char;
    logic [6:0]        w_len;
    logic [IDX_W-1:0]  w_leave_idx;
    logic              w_sat;
    logic [POS_W-1:0]  w_cs_inc;
    logic              w_hv;
    logic [HASH_W-1:0] w_weight;
    logic [HASH_W-1:0] w_comp;
    logic [37:0]       w_prod;
    logic [38:0]       w_sum;
    logic [46:0]       w_shift;
    logic [HASH_W:0]   w_fold;
    logic [HASH_W:0]   w_red;
    logic [HASH_W-1:0] w_hnew;

    // effective window length 1..WINDOW_MAX
    assign w_len = (i_cfg.word_length == '0) ? 7'd1 :
                   ({1'b0, i_cfg.word_length} > 7'(WINDOW_MAX)) ? 7'(WINDOW_MAX) :
                   {1'b0, i_cfg.word_length};
    assign w_leave_idx = IDX_W'(w_len - 7'd1);

    assign w_sat    = (r_cs == '1);
    assign w_cs_inc = w_sat ? r_cs : r_cs + 32'd1;
    assign w_hv     = (w_cs_inc >= 32'(w_len));

    assign w_weight = (i_cfg.leading_weight >= HASH_Q) ? i_cfg.leading_weight - HASH_Q
                                                      : i_cfg.leading_weight;
    assign w_comp   = HASH_Q - w_weight;
    assign w_prod   = 38'(r_leave) * 38'(w_comp);

    // (h + p) * 256 + c, then fold the bits above 2^30 back in
    assign w_sum   = 39'(r_hash) + 39'(r_prod);
    assign w_shift = {w_sum, r_char};
    assign w_fold  = 31'(w_shift[46:HASH_W]) * HASH_FOLD + {1'b0, w_shift[HASH_W-1:0]};

    assign w_red  = (r_fold[HASH_W] ? HASH_FOLD : '0) + {1'b0, r_fold[HASH_W-1:0]};
    assign w_hnew = (w_red >= {1'b0, HASH_Q}) ? HASH_W'(w_red - {1'b0, HASH_Q})
                                              : w_red[HASH_W-1:0];

    assign o_in_stall  = (r_state != S_IDLE) || (r_req.vld && !i_adv);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_take_char = w_accept && (i_in_data.action == ACT_CHAR);
    assign o_req       = r_req;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_hash  = r_hash;
        n_cs    = r_cs;
        if (i_adv) begin
            n_req.vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_data.action) inside
                        ACT_CHAR: begin
                            n_cs    = w_cs_inc;
                            n_state = S_MUL;
                        end
                        ACT_START, ACT_LOAD, ACT_CLEAR: begin
                            if (i_in_data.action == ACT_START) begin
                                n_hash = '0;
                                n_cs   = '0;
                            end
                            n_req.vld          = 1'b1;
                            n_req.action       = i_in_data.action;
                            n_req.slot_index   = i_in_data.slot_index;
                            n_req.pattern_hash = i_in_data.pattern_hash;
                            n_req.hash_valid   = 1'b0;
                            n_req.window_hash  = (i_in_data.action == ACT_START) ? '0
                                                                                 : r_hash;
                            n_req.hit          = 1'b0;
                            n_req.hit_slot     = '0;
                            n_req.window_start = '0;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                n_hash             = w_hnew;
                n_req.vld          = 1'b1;
                n_req.action       = ACT_CHAR;
                n_req.slot_index   = '0;
                n_req.pattern_hash = '0;
                n_req.hash_valid   = r_hv;
                n_req.window_hash  = w_hnew;
                n_req.hit          = 1'b0;
                n_req.hit_slot     = '0;
                n_req.window_start = r_ws;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_req.vld <= 1'b0;
            r_hash    <= '0;
            r_cs      <= '0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_hash  <= n_hash;
            r_cs    <= n_cs;
        end
    end

    // window shift line and per-character working registers
    always_ff @(posedge i_clk) begin
        if (w_take_char) begin
            r_win[0] <= i_in_data.char_code;
            for (int k = 1; k < WINDOW_MAX; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_char  <= i_in_data.char_code;
            r_leave <= r_win[w_leave_idx];
            r_full  <= (r_cs >= 32'(w_len));
            r_hv    <= w_hv;
            r_ws    <= !w_hv ? '0 : (w_sat ? '1 : w_cs_inc - 32'(w_len));
        end
        if (r_state == S_MUL) begin
            r_prod <= r_full ? w_prod : '0;
        end
        if (r_state == S_FOLD) begin
            r_fold <= w_fold;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rhmpf_slot_cell.sv =====
// ----------------------------------------------------------------------------
// Pattern slot cell
// Holds one pattern hash and its valid bit; checks each passing request
// and hands it to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhmpf_slot_cell
    import rhmpf_pkg::*;
#(
    parameter int SLOT_INDEX = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire t_req i_req,
    output t_req      o_req
);

    localparam logic [31:0]       SLOT_ID  = 32'(SLOT_INDEX);
    localparam logic [SLOT_W-1:0] SLOT_TAG = SLOT_W'(SLOT_INDEX);

    t_req              r_req, n_req;
    logic              r_slot_vld;
    logic [HASH_W-1:0] r_slot_hash;
    logic              w_mine;

    assign w_mine = (32'(i_req.slot_index) == SLOT_ID);
    assign o_req  = r_req;

    // earlier cells win, so only a request without a hit is marked
    always_comb begin
        n_req = i_req;
        if (i_req.vld && (i_req.action == ACT_CHAR) && i_req.hash_valid && !i_req.hit
                && r_slot_vld && (r_slot_hash == i_req.window_hash)) begin
            n_req.hit      = 1'b1;
            n_req.hit_slot = SLOT_TAG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.vld  <= 1'b0;
            r_slot_vld <= 1'b0;
        end else if (i_adv) begin
            r_req <= n_req;
            if (i_req.vld && (i_req.action == ACT_LOAD) && w_mine) begin
                r_slot_vld <= 1'b1;
            end else if (i_req.vld && (i_req.action == ACT_CLEAR)) begin
                r_slot_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_req.vld && (i_req.action == ACT_LOAD) && w_mine) begin
            r_slot_hash <= i_req.pattern_hash;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rolling_hash_multi_pattern_filter_core.sv =====
// ----------------------------------------------------------------------------
// Rolling hash multi-pattern filter core
// Path: a text character passes the roll states S_MUL, S_FOLD and S_REDUCE,
//   then the issue register and each slot cell; other actions go straight in.
// Throughput: a character holds off new requests until its three-step roll is
//   done; other requests one per cycle while the result channel does not stall.
// Reset: clears state, hash, count, slot valid bits and config to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rolling_hash_multi_pattern_filter_core
    import rhmpf_pkg::*;
#(
    parameter int WINDOW_MAX  = 32,
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [HASH_W-1:0]    i_cfg_data
);

    // Configuration registers: issue writes only while the core is idle; the
    // block does not enforce this. Writes can be taken on every cycle.
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_length    <= 6'd4;
            r_cfg.leading_weight <= 30'd16777216;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WORD_LENGTH:    r_cfg.word_length    <= i_cfg_data[WLEN_W-1:0];
                REG_LEADING_WEIGHT: r_cfg.leading_weight <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Chain of requests: entry 0 is the hash unit's issue register, entry k+1
    // the register of slot cell k. Every request, text or table command, walks
    // the whole chain in order, so each slot sees loads, clears and searches
    // in the order they were accepted.
    t_req w_chain [TABLE_DEPTH+1];
    t_req w_tail;
    logic w_adv;

    // The chain moves as one; it freezes only while the tail result is held
    // back by the consumer.
    assign w_tail = w_chain[TABLE_DEPTH];
    assign w_adv  = !(w_tail.vld && i_out_stall);

    rhmpf_hash_unit #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_adv      (w_adv),
        .o_req      (w_chain[0])
    );

    // One cell per pattern slot; the lowest matching slot marks the hit first.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_slot
        rhmpf_slot_cell #(
            .SLOT_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_req   (w_chain[g]),
            .o_req   (w_chain[g+1])
        );
    end

    assign o_out_valid             = w_tail.vld;
    assign o_out_data.hash_valid   = w_tail.hash_valid;
    assign o_out_data.window_hash  = w_tail.window_hash;
    assign o_out_data.hit          = w_tail.hit;
    assign o_out_data.hit_slot     = w_tail.hit_slot;
    assign o_out_data.window_start = w_tail.window_start;

    // a taken character keeps the hash unit busy for its roll
    a_char_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.action == ACT_CHAR)) |=> o_in_stall)
        else $error("hash unit took a request during a roll");

    // an issued request is never dropped while the chain is frozen
    a_issue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chain[0].vld && !w_adv) |=> w_chain[0].vld)
        else $error("issue request lost under stall");

    // results without a full window carry no hit and no position
    a_no_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hash_valid) |->
        (!o_out_data.hit && (o_out_data.hit_slot == '0) && (o_out_data.window_start == '0)))
        else $error("hit or position without a full window");

    // the rolled hash is always fully reduced
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.window_hash < HASH_Q))
        else $error("window hash not reduced");

endmodule

`default_nettype wire
